// File: sv/pts_pkg.sv
// ============================================================================
// pts_pkg
// Shared types and fixed field widths for the position-triggered pulse
// scheduler.
// ============================================================================
package pts_pkg;

    // Phase of the pulse machine.
    typedef enum logic [1:0] {
        PH_GET        = 2'd0,
        PH_WAIT_SET   = 2'd1,
        PH_WAIT_RESET = 2'd2
    } phase_t;

    // Work left for the finish state of a request.
    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_POP        = 2'd1,
        ACT_WAIT_SET   = 2'd2,
        ACT_WAIT_RESET = 2'd3
    } act_t;

    localparam int FIRED_W    = 32;
    localparam int LEVEL_W    = 5;
    localparam int CFG_W      = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    // Bit positions in the input tuser.
    localparam int USER_RESET_BIT = 0;
    localparam int USER_PUSH_BIT  = 1;

endpackage

// File: sv/position_triggered_pulse_scheduler.sv
// ============================================================================
// position_triggered_pulse_scheduler
// Output: a result is loaded into the output register in the finish state
//   that follows the acceptance of its request, once no earlier result is held.
// Requests: a new request is taken only after the last one leaves the finish
//   state, which uses the registered memory read; a held result stalls it.
// Reset: rst_n is asynchronous and clears the FIFO pointers, the phase, the
//   pulse counter and the pulse length; the target memory is not cleared.
// ============================================================================
module position_triggered_pulse_scheduler
    import pts_pkg::*;
#(
    parameter int FIFO_DEPTH = 16,
    parameter int POS_WIDTH  = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Configuration write channel: pulse length in position units.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [CFG_W-1:0]                        cfg_data,

    // Scan request stream.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: push_position, set_position, reset_position (zero padded to bytes)
    input  logic [((3*POS_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: reset_req, push_req
    input  logic [IN_USER_W-1:0]                    s_axis_tuser,

    // Scan result stream.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata: pulse_out, pulse_rise, pulses_fired[31:0], fifo_level[4:0], overflow
    output logic [OUT_DATA_W-1:0]                   m_axis_tdata
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // Request handling takes two steps. In the accept cycle the push is
    // applied to the target memory, and in the get phase the oldest target
    // is read. In the finish cycle the read data (or the freshly pushed
    // value, when the push and the pop hit the same entry) becomes the next
    // start position, or the wait-set / wait-reset compares run, and the
    // result is loaded into the output register once it is free.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIN  = 1'b1
    } state_t;

    state_t                  state_reg,      state_next;
    phase_t                  phase_reg,      phase_next;
    act_t                    act_reg,        act_next;
    logic [AW-1:0]           wr_idx_reg,     wr_idx_next;
    logic [AW-1:0]           rd_idx_reg,     rd_idx_next;
    logic [CW-1:0]           count_reg,      count_next;
    logic [POS_WIDTH-1:0]    next_start_reg, next_start_next;
    logic [POS_WIDTH-1:0]    next_end_reg,   next_end_next;
    logic [FIRED_W-1:0]      fired_total_reg, fired_total_next;
    logic [CFG_W-1:0]        pulse_length_reg, pulse_length_next;

    // Fields of the request in flight.
    logic [POS_WIDTH-1:0]    set_pos_reg,    set_pos_next;
    logic [POS_WIDTH-1:0]    rst_pos_reg,    rst_pos_next;
    logic [POS_WIDTH-1:0]    fwd_data_reg,   fwd_data_next;
    logic                    fwd_reg,        fwd_next;
    logic                    ovf_reg,        ovf_next;

    // Output register.
    logic                    out_valid_reg,  out_valid_next;
    logic                    out_pulse_reg,  out_pulse_next;
    logic                    out_rise_reg,   out_rise_next;
    logic [FIRED_W-1:0]      out_fired_reg,  out_fired_next;
    logic [LEVEL_W-1:0]      out_level_reg,  out_level_next;
    logic                    out_ovf_reg,    out_ovf_next;

    // Target memory.
    logic [POS_WIDTH-1:0]    target_mem [FIFO_DEPTH];
    logic [POS_WIDTH-1:0]    mem_rdata_reg;
    logic                    mem_we;
    logic                    mem_re;

    logic [POS_WIDTH-1:0]    in_push_pos;
    logic [POS_WIDTH-1:0]    in_set_pos;
    logic [POS_WIDTH-1:0]    in_rst_pos;
    logic [POS_WIDTH:0]      end_sum;
    logic [POS_WIDTH-1:0]    end_sat;
    logic                    fin_go;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        idx_inc = (idx == AW'(FIFO_DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign in_push_pos = s_axis_tdata[POS_WIDTH-1:0];
    assign in_set_pos  = s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
    assign in_rst_pos  = s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ovf_reg, out_level_reg, out_fired_reg,
                            out_rise_reg, out_pulse_reg};

    // The pulse end position saturates at the largest position value.
    assign end_sum = {1'b0, set_pos_reg} + {1'b0, POS_WIDTH'(pulse_length_reg)};
    assign end_sat = end_sum[POS_WIDTH] ? '1 : end_sum[POS_WIDTH-1:0];

    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        logic [CW-1:0] cnt_v;
        logic          push_ok;

        cnt_v             = count_reg;
        push_ok           = 1'b0;

        state_next        = state_reg;
        phase_next        = phase_reg;
        act_next          = act_reg;
        wr_idx_next       = wr_idx_reg;
        rd_idx_next       = rd_idx_reg;
        count_next        = count_reg;
        next_start_next   = next_start_reg;
        next_end_next     = next_end_reg;
        fired_total_next  = fired_total_reg;
        pulse_length_next = cfg_valid ? cfg_data : pulse_length_reg;
        set_pos_next      = set_pos_reg;
        rst_pos_next      = rst_pos_reg;
        fwd_data_next     = fwd_data_reg;
        fwd_next          = fwd_reg;
        ovf_next          = ovf_reg;

        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_pulse_next    = out_pulse_reg;
        out_rise_next     = out_rise_reg;
        out_fired_next    = out_fired_reg;
        out_level_next    = out_level_reg;
        out_ovf_next      = out_ovf_reg;

        mem_we            = 1'b0;
        mem_re            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next    = S_FIN;
                    set_pos_next  = in_set_pos;
                    rst_pos_next  = in_rst_pos;
                    fwd_data_next = in_push_pos;
                    fwd_next      = 1'b0;
                    ovf_next      = 1'b0;
                    act_next      = ACT_NONE;
                    if (s_axis_tuser[USER_RESET_BIT])
                    begin
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                        count_next  = '0;
                        phase_next  = PH_GET;
                    end
                    else
                    begin
                        if (s_axis_tuser[USER_PUSH_BIT])
                        begin
                            if (count_reg == CW'(FIFO_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                wr_idx_next = idx_inc(wr_idx_reg);
                                cnt_v       = count_reg + CW'(1);
                                push_ok     = 1'b1;
                            end
                        end
                        case (phase_reg)
                            PH_GET:
                            begin
                                if (cnt_v != '0)
                                begin
                                    mem_re      = 1'b1;
                                    rd_idx_next = idx_inc(rd_idx_reg);
                                    cnt_v       = cnt_v - CW'(1);
                                    phase_next  = PH_WAIT_SET;
                                    act_next    = ACT_POP;
                                    // Pop of the entry written in this same cycle.
                                    fwd_next    = push_ok && (wr_idx_reg == rd_idx_reg);
                                end
                            end
                            PH_WAIT_SET:
                            begin
                                act_next = ACT_WAIT_SET;
                            end
                            PH_WAIT_RESET:
                            begin
                                act_next = ACT_WAIT_RESET;
                            end
                            default:
                            begin
                                phase_next = PH_GET;
                            end
                        endcase
                        count_next = cnt_v;
                    end
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_pulse_next = 1'b0;
                    out_rise_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    out_level_next = LEVEL_W'(count_reg);
                    case (act_reg)
                        ACT_POP:
                        begin
                            next_start_next = fwd_reg ? fwd_data_reg : mem_rdata_reg;
                        end
                        ACT_WAIT_SET:
                        begin
                            if (set_pos_reg >= next_start_reg)
                            begin
                                out_pulse_next   = 1'b1;
                                out_rise_next    = 1'b1;
                                next_end_next    = end_sat;
                                fired_total_next = fired_total_reg + FIRED_W'(1);
                                phase_next       = PH_WAIT_RESET;
                            end
                        end
                        ACT_WAIT_RESET:
                        begin
                            if (rst_pos_reg >= next_end_reg)
                            begin
                                phase_next = PH_GET;
                            end
                            else
                            begin
                                out_pulse_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_fired_next = fired_total_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_GET;
            act_reg          <= ACT_NONE;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            count_reg        <= '0;
            next_start_reg   <= '0;
            next_end_reg     <= '0;
            fired_total_reg  <= '0;
            pulse_length_reg <= '0;
            set_pos_reg      <= '0;
            rst_pos_reg      <= '0;
            fwd_data_reg     <= '0;
            fwd_reg          <= 1'b0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pulse_reg    <= 1'b0;
            out_rise_reg     <= 1'b0;
            out_fired_reg    <= '0;
            out_level_reg    <= '0;
            out_ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            act_reg          <= act_next;
            wr_idx_reg       <= wr_idx_next;
            rd_idx_reg       <= rd_idx_next;
            count_reg        <= count_next;
            next_start_reg   <= next_start_next;
            next_end_reg     <= next_end_next;
            fired_total_reg  <= fired_total_next;
            pulse_length_reg <= pulse_length_next;
            set_pos_reg      <= set_pos_next;
            rst_pos_reg      <= rst_pos_next;
            fwd_data_reg     <= fwd_data_next;
            fwd_reg          <= fwd_next;
            ovf_reg          <= ovf_next;
            out_valid_reg    <= out_valid_next;
            out_pulse_reg    <= out_pulse_next;
            out_rise_reg     <= out_rise_next;
            out_fired_reg    <= out_fired_next;
            out_level_reg    <= out_level_next;
            out_ovf_reg      <= out_ovf_next;
        end
    end

    // Target memory: one write port, one registered read port. A read of the
    // entry written in the same cycle returns old data; the forward path
    // above covers that case.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            target_mem[wr_idx_reg] <= in_push_pos;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= target_mem[rd_idx_reg];
        end
    end

`ifndef SYNTHESIS
    // The number of pending targets never exceeds the FIFO depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("pending target count exceeds FIFO depth");

    // Every rising edge loaded into the output advances the pulse counter.
    a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go && out_rise_next |=> fired_total_reg == $past(fired_total_reg) + FIRED_W'(1))
        else $error("pulse counter did not advance on a rising edge");

    // In the cycle after a request is accepted, the request input is not ready.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the position-triggered pulse scheduler. Scans go in
// on the request stream and a scoreboard model of the target FIFO and the
// get / wait-set / wait-reset machine predicts every result. A checker
// compares each result field by field. Random gaps on the request side and
// random stalls on the result side run throughout. Some stretches have no
// idling at all, and long result stalls back the block up.
// ============================================================================
module tb;

    import pts_pkg::*;

    localparam int          RING_DEPTH   = 16;
    localparam int          POS_W        = 32;
    localparam int          SCAN_DATA_W  = ((3 * POS_W + 7) / 8) * 8;
    localparam int          LONG_HOLD    = 80;
    localparam int          PHASE_SCANS  = 250;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          REPORT_LIMIT = 40;

    // One scan as the sender sees it.
    typedef struct packed {
        logic             reset_req;
        logic             push_req;
        logic [POS_W-1:0] push_pos;
        logic [POS_W-1:0] set_pos;
        logic [POS_W-1:0] reset_pos;
    } scan_req_t;

    // One result, laid out exactly like m_axis_tdata (pulse_out in bit 0).
    typedef struct packed {
        logic                 ovf;
        logic [LEVEL_W-1:0]   level;
        logic [FIRED_W-1:0]   fired;
        logic                 rise;
        logic                 pulse;
    } scan_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;

    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [SCAN_DATA_W-1:0]  s_axis_tdata;   // push_position, set_position, reset_position
    logic [IN_USER_W-1:0]    s_axis_tuser;   // reset_req, push_req

    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // pulse_out, pulse_rise, pulses_fired,
                                             // fifo_level, overflow

    // Scoreboard model of the block: target ring, pointers, phase and counters.
    logic [POS_W-1:0]   target_ring [RING_DEPTH];
    logic [3:0]         wr_ptr;
    logic [3:0]         rd_ptr;
    logic [4:0]         pending;
    phase_t             ring_phase;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic [FIRED_W-1:0] fired;
    logic [CFG_W-1:0]   pulse_len;

    scan_result_t       expected_scans [$];
    int unsigned        mismatches = 0;
    int unsigned        cycle_count = 0;
    logic [POS_W-1:0]   belt;

    // Idle control shared between the request side and the result side.
    logic               no_idle = 1'b0;
    int unsigned        hold_requests = 0;

    position_triggered_pulse_scheduler #(
        .FIFO_DEPTH (RING_DEPTH),
        .POS_WIDTH  (POS_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hang guard. A correct run needs a small fraction of this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    // Works out the result of one accepted scan and advances the model state.
    // Reset request wins over a push; a push is taken before the phase machine
    // runs, so a target pushed into an empty ring in the get phase is popped in
    // the same scan.
    function automatic scan_result_t predict_scan(input scan_req_t req);
        scan_result_t res;
        logic [POS_W:0] end_sum;
        res = '0;
        if (req.reset_req)
        begin
            // The counter and the start/end positions survive a reset request.
            wr_ptr     = '0;
            rd_ptr     = '0;
            pending    = '0;
            ring_phase = PH_GET;
        end
        else
        begin
            if (req.push_req)
            begin
                if (pending >= RING_DEPTH)
                    res.ovf = 1'b1;
                else
                begin
                    target_ring[wr_ptr] = req.push_pos;
                    wr_ptr  = wr_ptr + 1'b1;
                    pending = pending + 1'b1;
                end
            end
            case (ring_phase)
                PH_GET:
                begin
                    if (pending > 0)
                    begin
                        start_pos  = target_ring[rd_ptr];
                        rd_ptr     = rd_ptr + 1'b1;
                        pending    = pending - 1'b1;
                        ring_phase = PH_WAIT_SET;
                    end
                end
                PH_WAIT_SET:
                begin
                    if (req.set_pos >= start_pos)
                    begin
                        res.pulse = 1'b1;
                        res.rise  = 1'b1;
                        // The pulse end saturates instead of wrapping.
                        end_sum    = {1'b0, req.set_pos} + {1'b0, pulse_len};
                        end_pos    = end_sum[POS_W] ? '1 : end_sum[POS_W-1:0];
                        fired      = fired + 1'b1;
                        ring_phase = PH_WAIT_RESET;
                    end
                end
                PH_WAIT_RESET:
                begin
                    if (req.reset_pos >= end_pos)
                        ring_phase = PH_GET;
                    else
                        res.pulse = 1'b1;
                end
                default:
                    ring_phase = PH_GET;
            endcase
        end
        res.fired = fired;
        res.level = pending;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    // Every result that is taken is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = scan_result_t'(m_axis_tdata);
            if (expected_scans.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = expected_scans.pop_front();
                check_field("pulse_out",    want.pulse, got.pulse);
                check_field("pulse_rise",   want.rise,  got.rise);
                check_field("pulses_fired", want.fired, got.fired);
                check_field("fifo_level",   want.level, got.level);
                check_field("overflow",     want.ovf,   got.ovf);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idle lengths: mostly short, now and then long.
    // ------------------------------------------------------------------------

    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned request_gap();
        if (no_idle || $urandom_range(0, 99) < 55)
            return 0;
        return idle_length();
    endfunction

    // Result side: random stalls, plus a long hold whenever a test asks for
    // one. The hold is counted here so the sender keeps offering requests.
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned hold_served;
        hold_left   = 0;
        stall_left  = 0;
        hold_served = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_length() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one scan and waits for it to be taken. tvalid stays high after
    // acceptance so back-to-back requests never toggle it within a step.
    task automatic send_scan(input scan_req_t req);
        int unsigned gap;
        logic [IN_USER_W-1:0] user;
        gap = request_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        user = '0;
        user[USER_RESET_BIT] = req.reset_req;
        user[USER_PUSH_BIT]  = req.push_req;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.reset_pos, req.set_pos, req.push_pos};
        s_axis_tuser  <= user;
        do @(posedge clk); while (!s_axis_tready);
        expected_scans.push_back(predict_scan(req));
    endtask

    // The sender goes quiet until every outstanding result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_scans.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The length register is only written with the block idle.
    task automatic set_pulse_length(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pulse_len = value;
    endtask

    function automatic scan_req_t make_scan(input logic rr, input logic pr,
                                            input logic [POS_W-1:0] push_pos,
                                            input logic [POS_W-1:0] set_pos,
                                            input logic [POS_W-1:0] reset_pos);
        scan_req_t req;
        req.reset_req = rr;
        req.push_req  = pr;
        req.push_pos  = push_pos;
        req.set_pos   = set_pos;
        req.reset_pos = reset_pos;
        return req;
    endfunction

    // A belt that creeps forward, with targets pushed a little ahead of it.
    // This is the traffic that actually exercises fire and release.
    function automatic scan_req_t conveyor_scan();
        scan_req_t req;
        belt = belt + $urandom_range(0, 3);
        req.reset_req = ($urandom_range(0, 149) == 0);
        req.push_req  = ($urandom_range(0, 3) == 0);
        req.push_pos  = belt + $urandom_range(0, 48);
        req.set_pos   = belt;
        req.reset_pos = ($urandom_range(0, 7) == 0) ? belt - $urandom_range(0, 8) : belt;
        return req;
    endfunction

    // Arbitrary scans; a reset position at full scale frees a long pulse.
    function automatic scan_req_t noise_scan();
        scan_req_t req;
        req.reset_req = ($urandom_range(0, 19) == 0);
        req.push_req  = $urandom_range(0, 1);
        req.push_pos  = $urandom();
        req.set_pos   = $urandom();
        req.reset_pos = ($urandom_range(0, 3) == 0) ? '1 : $urandom();
        return req;
    endfunction

    // Belt start: near zero, near full scale so it wraps, or anywhere.
    task automatic start_belt();
        case ($urandom_range(0, 3))
            0:       belt = $urandom_range(0, 64);
            1:       belt = 32'hFFFF_FF80 + $urandom_range(0, 64);
            default: belt = $urandom();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero length: a target at zero is popped in its push scan, fires on the
    // next and is released at once.
    task automatic test_fire_release();
        send_scan(make_scan(1'b0, 1'b1, '0, '0, '0));
        send_scan(make_scan(1'b0, 1'b0, '0, '0, '0));
        send_scan(make_scan(1'b0, 1'b0, '0, '0, '0));
        drain_results();
    endtask

    // Full-scale length: set position plus length overflows and the end
    // position sticks at full scale.
    task automatic test_end_saturation();
        set_pulse_length('1);
        send_scan(make_scan(1'b0, 1'b1, 32'd1, '0, '0));
        send_scan(make_scan(1'b0, 1'b0, '0, 32'd1, '0));
        send_scan(make_scan(1'b0, 1'b0, '0, '0, 32'hFFFF_FFFE));
        send_scan(make_scan(1'b0, 1'b0, '0, '0, '1));
        drain_results();
    endtask

    // The first target (full scale) never fires, so the ring fills to 16 and
    // the next push is dropped. A reset request with a push then clears it
    // all, and a later scan must not fire on a stale target.
    task automatic test_full_fifo();
        int i;
        send_scan(make_scan(1'b0, 1'b1, '1, '0, '0));
        for (i = 0; i < RING_DEPTH + 1; i++)
            send_scan(make_scan(1'b0, 1'b1, (i == 0) ? '0 : $urandom(), '0, '0));
        send_scan(make_scan(1'b1, 1'b1, $urandom(), '0, '0));
        send_scan(make_scan(1'b0, 1'b0, $urandom(), '1, '1));
        drain_results();
    endtask

    // No gaps from the sender while the result side holds off for a long
    // stretch: the block has to fill up and stall its request input.
    task automatic test_backpressure();
        int i;
        set_pulse_length(32'd6);
        start_belt();
        no_idle <= 1'b1;
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 40; i++)
            send_scan(conveyor_scan());
        drain_results();
        no_idle <= 1'b0;
    endtask

    // Random traffic under a range of pulse lengths, extremes included. One
    // phase runs without idling; every other phase takes a long result hold.
    task automatic test_random_phases();
        logic [CFG_W-1:0] lengths [6];
        int k;
        int n;
        lengths[0] = '0;
        lengths[1] = $urandom_range(1, 16);
        lengths[2] = 32'd100;
        lengths[3] = 32'h8000_0000;
        lengths[4] = '1;
        lengths[5] = $urandom();
        for (k = 0; k < 6; k++)
        begin
            set_pulse_length(lengths[k]);
            start_belt();
            no_idle <= (k == 2);
            for (n = 0; n < PHASE_SCANS; n++)
            begin
                if (n == PHASE_SCANS / 2 && k % 2 == 1)
                    hold_requests <= hold_requests + 1;
                if ($urandom_range(0, 99) < 82)
                    send_scan(conveyor_scan());
                else
                    send_scan(noise_scan());
            end
            drain_results();
        end
        no_idle <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // Model state after reset; the ring contents are never read unwritten.
        wr_ptr     = '0;
        rd_ptr     = '0;
        pending    = '0;
        ring_phase = PH_GET;
        start_pos  = '0;
        end_pos    = '0;
        fired      = '0;
        pulse_len  = '0;
        belt       = '0;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_fire_release();
        test_end_saturation();
        test_full_fifo();
        test_backpressure();
        test_random_phases();

        // Everything has drained; the idle wait that follows catches any stray result.
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_scans.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
